// File: rtl/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } mlr_op_e;

  typedef struct packed {
    logic steep;
    logic col_step_neg;
    logic row_step_neg;
  } mlr_dir_t;

endpackage

// File: rtl/mlr_setup.sv
// ----------------------------------------------------------------------------
// mlr_setup
// Line setup: step signs, absolute deltas, major axis, decision term and
// increments for a new line.
// ----------------------------------------------------------------------------
module mlr_setup #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]   start_x_i,
  input  logic [COORD_BITS-1:0]   start_y_i,
  input  logic [COORD_BITS-1:0]   end_x_i,
  input  logic [COORD_BITS-1:0]   end_y_i,
  output mlr_pkg::mlr_dir_t       dir_o,
  output logic signed [COORD_BITS+3:0] decision_o,
  output logic signed [COORD_BITS+3:0] inc_straight_o,
  output logic signed [COORD_BITS+3:0] inc_diagonal_o,
  output logic                    last_o
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [COORD_BITS-1:0] major;
  logic [COORD_BITS-1:0] minor;
  logic signed [COORD_BITS+3:0] minor2;
  logic signed [COORD_BITS+3:0] major1;
  logic signed [COORD_BITS+3:0] major2;

  always_comb begin
    dir_o.col_step_neg = end_x_i < start_x_i;
    dir_o.row_step_neg = end_y_i < start_y_i;
    dx = dir_o.col_step_neg ? start_x_i - end_x_i : end_x_i - start_x_i;
    dy = dir_o.row_step_neg ? start_y_i - end_y_i : end_y_i - start_y_i;
    dir_o.steep = dy > dx;
    major = dir_o.steep ? dy : dx;
    minor = dir_o.steep ? dx : dy;
    minor2 = $signed({3'b000, minor, 1'b0});
    major2 = $signed({3'b000, major, 1'b0});
    major1 = $signed({4'b0000, major});
    inc_straight_o = minor2;
    inc_diagonal_o = minor2 - major2;
    decision_o     = minor2 - major1;
    last_o = (start_x_i == end_x_i) && (start_y_i == end_y_i);
  end

endmodule

// File: rtl/mlr_step.sv
// ----------------------------------------------------------------------------
// mlr_step
// One rasterizer step: advance the major axis, take a diagonal step on a
// positive decision term, and flag arrival at the target.
// ----------------------------------------------------------------------------
module mlr_step #(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        cur_col_i,
  input  logic [COORD_BITS-1:0]        cur_row_i,
  input  logic [COORD_BITS-1:0]        target_col_i,
  input  logic [COORD_BITS-1:0]        target_row_i,
  input  logic signed [COORD_BITS+3:0] decision_i,
  input  logic signed [COORD_BITS+3:0] inc_straight_i,
  input  logic signed [COORD_BITS+3:0] inc_diagonal_i,
  input  mlr_pkg::mlr_dir_t            dir_i,
  output logic [COORD_BITS-1:0]        cur_col_o,
  output logic [COORD_BITS-1:0]        cur_row_o,
  output logic signed [COORD_BITS+3:0] decision_o,
  output logic                         last_o
);

  logic                  diag;
  logic [COORD_BITS-1:0] col_stepped;
  logic [COORD_BITS-1:0] row_stepped;

  always_comb begin
    diag = !decision_i[COORD_BITS+3] && (|decision_i);
    decision_o = decision_i + (diag ? inc_diagonal_i : inc_straight_i);
    col_stepped = dir_i.col_step_neg ? cur_col_i - COORD_BITS'(1)
                                     : cur_col_i + COORD_BITS'(1);
    row_stepped = dir_i.row_step_neg ? cur_row_i - COORD_BITS'(1)
                                     : cur_row_i + COORD_BITS'(1);
    if (dir_i.steep) begin
      cur_row_o = row_stepped;
      cur_col_o = diag ? col_stepped : cur_col_i;
      last_o    = row_stepped == target_row_i;
    end else begin
      cur_col_o = col_stepped;
      cur_row_o = diag ? row_stepped : cur_row_i;
      last_o    = col_stepped == target_col_i;
    end
  end

endmodule

// File: rtl/midpoint_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_top
// Midpoint line rasterizer for all octants, one pixel per transaction.
// ----------------------------------------------------------------------------
// A start transaction loads both endpoints and returns the first pixel; each
// next transaction returns the following pixel, with last_pixel_o set on the
// second endpoint. A next transaction with no line active returns nothing.
// The block takes one transaction per clock and returns its pixel in the next
// cycle from the output register; the input side stalls only while that
// register holds a pixel that the output side is stalling. Each step is one
// add of the decision term and one coordinate compare.
module midpoint_line_rasterizer_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_pixel_o
);

  localparam int DecW = COORD_BITS + 4;

  logic [COORD_BITS-1:0] cur_col_q, cur_col_d;
  logic [COORD_BITS-1:0] cur_row_q, cur_row_d;
  logic [COORD_BITS-1:0] target_col_q, target_col_d;
  logic [COORD_BITS-1:0] target_row_q, target_row_d;
  logic signed [DecW-1:0] decision_q, decision_d;
  logic signed [DecW-1:0] inc_straight_q, inc_straight_d;
  logic signed [DecW-1:0] inc_diagonal_q, inc_diagonal_d;
  mlr_pkg::mlr_dir_t      dir_q, dir_d;
  logic                   active_q, active_d;

  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] pixel_x_q, pixel_x_d;
  logic [COORD_BITS-1:0] pixel_y_q, pixel_y_d;
  logic                  last_q, last_d;

  mlr_pkg::mlr_dir_t      setup_dir;
  logic signed [DecW-1:0] setup_decision;
  logic signed [DecW-1:0] setup_inc_straight;
  logic signed [DecW-1:0] setup_inc_diagonal;
  logic                   setup_last;

  logic [COORD_BITS-1:0] step_col;
  logic [COORD_BITS-1:0] step_row;
  logic signed [DecW-1:0] step_decision;
  logic                   step_last;

  logic    in_accept;
  logic    is_start;
  logic    is_next;
  logic    emit;

  mlr_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .dir_o          (setup_dir),
    .decision_o     (setup_decision),
    .inc_straight_o (setup_inc_straight),
    .inc_diagonal_o (setup_inc_diagonal),
    .last_o         (setup_last)
  );

  mlr_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .cur_col_i      (cur_col_q),
    .cur_row_i      (cur_row_q),
    .target_col_i   (target_col_q),
    .target_row_i   (target_row_q),
    .decision_i     (decision_q),
    .inc_straight_i (inc_straight_q),
    .inc_diagonal_i (inc_diagonal_q),
    .dir_i          (dir_q),
    .cur_col_o      (step_col),
    .cur_row_o      (step_row),
    .decision_o     (step_decision),
    .last_o         (step_last)
  );

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_start   = in_accept && (operation_i == mlr_pkg::OP_START);
  assign is_next    = in_accept && (operation_i == mlr_pkg::OP_NEXT) && active_q;
  assign emit       = is_start || is_next;

  always_comb begin
    cur_col_d      = cur_col_q;
    cur_row_d      = cur_row_q;
    target_col_d   = target_col_q;
    target_row_d   = target_row_q;
    decision_d     = decision_q;
    inc_straight_d = inc_straight_q;
    inc_diagonal_d = inc_diagonal_q;
    dir_d          = dir_q;
    active_d       = active_q;
    pixel_x_d      = pixel_x_q;
    pixel_y_d      = pixel_y_q;
    last_d         = last_q;
    if (is_start) begin
      cur_col_d      = start_x_i;
      cur_row_d      = start_y_i;
      target_col_d   = end_x_i;
      target_row_d   = end_y_i;
      decision_d     = setup_decision;
      inc_straight_d = setup_inc_straight;
      inc_diagonal_d = setup_inc_diagonal;
      dir_d          = setup_dir;
      active_d       = !setup_last;
      pixel_x_d      = start_x_i;
      pixel_y_d      = start_y_i;
      last_d         = setup_last;
    end else if (is_next) begin
      cur_col_d  = step_col;
      cur_row_d  = step_row;
      decision_d = step_decision;
      active_d   = !step_last;
      pixel_x_d  = step_col;
      pixel_y_d  = step_row;
      last_d     = step_last;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      dir_q       <= '0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      dir_q       <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_col_q      <= cur_col_d;
    cur_row_q      <= cur_row_d;
    target_col_q   <= target_col_d;
    target_row_q   <= target_row_d;
    decision_q     <= decision_d;
    inc_straight_q <= inc_straight_d;
    inc_diagonal_q <= inc_diagonal_d;
    pixel_x_q      <= pixel_x_d;
    pixel_y_q      <= pixel_y_d;
    last_q         <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pixel_x_q;
  assign pixel_y_o    = pixel_y_q;
  assign last_pixel_o = last_q;

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && last_d |=> !active_q)
    else $error("line still active after its last pixel");

  a_start_opens_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_start && !setup_last |=> active_q && out_valid_q && !last_pixel_o)
    else $error("start of a non-degenerate line did not open it");

  a_idle_next_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (operation_i == mlr_pkg::OP_NEXT) && !active_q |=> !out_valid_q)
    else $error("pixel emitted with no line active");

  a_stall_needs_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with output register empty");

endmodule
